// File: rtl/deq_pkg.sv
// ============================================================================
// deq_pkg: shared types for the double-ended queue unit
// Operation and status codes, payload types, FSM states and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package deq_pkg;

    localparam int MODE_W = 3;
    localparam int FILL_W = 5;

    typedef logic signed [31:0] t_word;
    typedef logic [FILL_W-1:0]  t_fill;

    // Operation codes carried on the mode field (other codes are no-ops)
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DUMP       = 3'd4
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;    // latch the incoming transaction
        logic exec;       // perform the operation on the ring
        logic rd_load;    // move memory read data into the result
        logic dump_step;  // advance the dump index and read the next entry
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic needs_read; // latched operation reads the memory
        logic more;       // current result is not the last of its item
    } t_dp_stat;

endpackage

// File: rtl/deq_in_if.sv
// ============================================================================
// deq_in_if: operation channel
// Valid/ready channel carrying one queue operation per transaction.
// ============================================================================
interface deq_in_if import deq_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    t_word             value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

// File: rtl/deq_out_if.sv
// ============================================================================
// deq_out_if: result channel
// Valid/ready channel carrying one queue result per transaction.
// ============================================================================
interface deq_out_if import deq_pkg::*; ();

    logic    valid;
    logic    ready;
    t_status status;
    t_word   data;
    t_fill   fill;
    logic    last;

    modport source (output valid, output status, output data, output fill,
                    output last, input ready);
    modport sink   (input valid, input status, input data, input fill,
                    input last, output ready);

endinterface

// File: rtl/deq_ctrl.sv
// ============================================================================
// deq_ctrl: queue controller
// Sequences one operation at a time: capture, execute, optional memory
// read, then hold the result until the consumer takes it; dumps loop back.
// ============================================================================
module deq_ctrl import deq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no transaction is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.needs_read ? S_READ : S_OUT;
            end
            S_READ: begin
                o_cmd.rd_load = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.more) begin
                        o_cmd.dump_step = 1'b1;
                        n_state         = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/deq_dp.sv
// ============================================================================
// deq_dp: queue datapath
// Ring memory with front pointer and occupancy count, dump index and
// the registered result word.
// ============================================================================
module deq_dp import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [MODE_W-1:0] i_mode,
    input  t_word             i_value,
    output t_status           o_status,
    output t_word             o_data,
    output t_fill             o_fill,
    output logic              o_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    // Ring slot of base + off, both below DEPTH
    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    // Occupancy reported on the 5-bit fill field
    function automatic t_fill f_fill(input logic [CW-1:0] cnt);
        logic [CW+FILL_W-1:0] ext;
        ext = {{FILL_W{1'b0}}, cnt};
        return ext[FILL_W-1:0];
    endfunction

    t_word             r_mem [DEPTH];
    t_word             r_rd_data;
    logic [MODE_W-1:0] r_mode;
    t_word             r_value;
    logic [PW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_idx, n_idx;
    t_status           r_status, n_status;
    t_word             r_data, n_data;
    t_fill             r_fill, n_fill;
    logic              r_last, n_last;

    logic          full, empty;
    logic [CW-1:0] cnt_m1;
    logic [PW:0]   idx_inc;
    logic          we, rd_en;
    logic [PW-1:0] wr_addr, rd_addr;

    assign full    = (r_count == DEPTH_C);
    assign empty   = (r_count == '0);
    assign cnt_m1  = r_count - 1'b1;
    assign idx_inc = {1'b0, r_idx} + 1'b1;

    assign o_stat.needs_read = !empty && (r_mode == MODE_POP_FRONT ||
                                          r_mode == MODE_POP_BACK  ||
                                          r_mode == MODE_DUMP);
    assign o_stat.more       = !r_last;

    // Operation execution and result formation
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_data   = r_data;
        n_fill   = r_fill;
        n_last   = r_last;
        we       = 1'b0;
        wr_addr  = r_front;
        rd_en    = 1'b0;
        rd_addr  = r_front;
        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_data   = '0;
            n_fill   = f_fill(r_count);
            n_last   = 1'b1;
            unique case (r_mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_OVER;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                        n_fill  = f_fill(n_count);
                        if (r_mode == MODE_PUSH_FRONT) begin
                            n_front = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
                            wr_addr = n_front;
                        end else begin
                            wr_addr = f_slot(r_front, r_count[PW-1:0]);
                        end
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK, MODE_DUMP: begin
                    if (empty) begin
                        n_status = ST_UNDER;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = '0;
                        if (r_mode == MODE_POP_FRONT) begin
                            n_front = f_slot(r_front, PW'(1));
                            n_count = cnt_m1;
                        end else if (r_mode == MODE_POP_BACK) begin
                            rd_addr = f_slot(r_front, cnt_m1[PW-1:0]);
                            n_count = cnt_m1;
                        end
                    end
                end
                default: begin
                    // unused codes: no operation
                end
            endcase
        end
        if (i_cmd.rd_load) begin
            n_status = ST_OK;
            n_data   = r_rd_data;
            n_fill   = f_fill(r_count);
            n_last   = (r_mode != MODE_DUMP) || (idx_inc == (PW + 1)'(r_count));
        end
        if (i_cmd.dump_step) begin
            n_idx   = idx_inc[PW-1:0];
            rd_en   = 1'b1;
            rd_addr = f_slot(r_front, idx_inc[PW-1:0]);
        end
    end

    // Ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Captured transaction, dump index and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_data   <= n_data;
        r_fill   <= n_fill;
        r_last   <= n_last;
    end

    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_fill   = r_fill;
    assign o_last   = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("occupancy above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !full &&
        (r_mode == MODE_PUSH_FRONT || r_mode == MODE_PUSH_BACK)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow the queue");

    a_dump_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_step |-> (r_mode == MODE_DUMP) && !r_last)
        else $error("dump step outside an unfinished dump");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && empty &&
        (r_mode == MODE_POP_FRONT || r_mode == MODE_POP_BACK || r_mode == MODE_DUMP)
        |=> r_status == ST_UNDER && r_fill == '0 && r_last)
        else $error("empty read did not report underflow");

endmodule

// File: rtl/double_ended_queue_unit.sv
// ============================================================================
// double_ended_queue_unit: bounded double-ended queue
// Ring store of signed 32-bit words with push/pop at both ends and a
// front-to-back dump; controller and datapath in separate modules.
// ============================================================================
//
//   Channel  | Direction | Payload                     | Transactions
//   ---------+-----------+-----------------------------+--------------------
//   i_in     | sink      | mode, value                 | one per operation
//   o_out    | source    | status, data, fill, last    | one, or one per
//            |           |                             | entry for a dump
//
// Pushes, refused operations and unused modes pass from accept through the
// execute state to the result; accepted pops and dumps add a read state
// before it, and a dump reads again for each further entry; the ring
// memory with registered read sets the extra read state. One operation is
// in flight at a time; i_in is ready only when idle and out of reset.
// Synchronous reset empties the queue at once; entry contents are
// undefined until written and need no clearing pass.
// A stalled o_out holds its result and the input stays blocked.
//
module double_ended_queue_unit import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_mode   (i_in.mode),
        .i_value  (i_in.value),
        .o_status (o_out.status),
        .o_data   (o_out.data),
        .o_fill   (o_out.fill),
        .o_last   (o_out.last)
    );

endmodule
